@@ design/uer_pkg.sv @@
// Package with shared constants, types and register indexes for the ultrasonic echo ranger.
`timescale 1ns / 1ps
`default_nettype none

package uer_pkg;

    // Counter and field widths.
    localparam int COUNT_BITS    = 17;
    localparam int TRIG_W_BITS   = 8;
    localparam int DIST_BITS     = 10;
    localparam int CFG_DATA_BITS = 17;
    localparam int CFG_ADDR_BITS = 1;
    localparam int IN_DATA_BITS  = 8;
    localparam int OUT_DATA_BITS = 16;

    // Saturation value of the tick counters.
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    // Register reset values.
    localparam logic [TRIG_W_BITS-1:0] TRIG_WIDTH_RESET = 8'd10;
    localparam logic [COUNT_BITS-1:0]  TIMEOUT_RESET    = 17'd70000;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_BITS-1:0] REG_TRIGGER_WIDTH = 1'b0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_TIMEOUT       = 1'b1;

    // Divide by 148: drop two low bits (divide by 4), then multiply by the
    // reciprocal of 37 scaled by 2^21. Exact for every 15-bit operand.
    localparam int DIV_PRE_SHIFT = 2;
    localparam int DIV_OP_BITS   = COUNT_BITS - DIV_PRE_SHIFT;
    localparam int DIV_MUL_BITS  = 16;
    localparam int DIV_SHIFT     = 21;
    localparam int DIV_PROD_BITS = DIV_OP_BITS + DIV_MUL_BITS;
    localparam logic [DIV_MUL_BITS-1:0] DIV_MULT = 16'd56681;

    // Measurement phase.
    typedef enum logic [1:0] {
        PH_TRIGGER = 2'd0,
        PH_WAIT    = 2'd1,
        PH_MEASURE = 2'd2
    } phase_t;

    // One result item.
    typedef struct packed {
        phase_t                phase;
        logic                  timed_out;
        logic [DIST_BITS-1:0]  distance_inches;
        logic                  distance_valid;
        logic                  trigger_level;
    } result_t;

endpackage

`default_nettype wire

@@ design/uer_div148.sv @@
// Constant divider: echo width in microseconds to whole inches.
`timescale 1ns / 1ps
`default_nettype none

module uer_div148 (
    input  wire logic [uer_pkg::COUNT_BITS-1:0] ticks,
    output logic      [uer_pkg::DIST_BITS-1:0]  inches
);
    import uer_pkg::*;

    logic [DIV_OP_BITS-1:0]   quarter;
    logic [DIV_PROD_BITS-1:0] product;

    // Divide by four with a shift, then by 37 with a reciprocal multiply.
    // The largest quotient is 885, so the result always fits.
    always_comb
    begin
        quarter = ticks[COUNT_BITS-1:DIV_PRE_SHIFT];
        product = DIV_PROD_BITS'(quarter) * DIV_PROD_BITS'(DIV_MULT);
        inches  = product[DIV_SHIFT +: DIST_BITS];
    end

endmodule

`default_nettype wire

@@ design/ultrasonic_echo_ranger.sv @@
// A result is registered and appears in the cycle after its tick request is accepted.
// Throughput: one tick per cycle while not stalled; the phase counters and the divide by 148
// settle combinationally between the state registers and the result register.
// Input is stalled only while the result register is full and not taken.
// Reset (asynchronous, active low) returns to the trigger phase with cleared
// counters, trigger width 10 us and timeout 70000 us.
`timescale 1ns / 1ps
`default_nettype none

module ultrasonic_echo_ranger (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // Slave stream: bit 0 echo_level, bits 7:1 zero.
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire logic [uer_pkg::IN_DATA_BITS-1:0]    s_axis_tdata,
    // Master stream: bit 0 trigger_level, bit 1 distance_valid,
    // bits 11:2 distance_inches, bit 12 timed_out, bits 14:13 phase, bit 15 zero.
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    output logic      [uer_pkg::OUT_DATA_BITS-1:0]   m_axis_tdata,
    // Configuration write port.
    input  wire logic                                cfg_wr_en,
    input  wire logic [uer_pkg::CFG_ADDR_BITS-1:0]   cfg_addr,
    input  wire logic [uer_pkg::CFG_DATA_BITS-1:0]   cfg_wdata
);
    import uer_pkg::*;

    logic [TRIG_W_BITS-1:0] trig_width_reg;
    logic [COUNT_BITS-1:0]  timeout_reg;

    phase_t                 phase_reg, phase_next;
    logic [COUNT_BITS-1:0]  phase_ticks_reg, phase_ticks_next;
    logic [COUNT_BITS-1:0]  echo_ticks_reg, echo_ticks_next;

    logic                   out_valid_reg;
    result_t                out_data_reg;
    result_t                result;

    logic                   accept;
    logic                   echo;
    logic [COUNT_BITS-1:0]  phase_inc;
    logic [COUNT_BITS-1:0]  echo_inc;
    logic [DIST_BITS-1:0]   div_inches;

    // Handshake: take a request whenever the result register is free or draining.
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign echo          = s_axis_tdata[0];

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_data_reg};

    // Saturating increments of both counters.
    assign phase_inc = (phase_ticks_reg == CNT_MAX) ? CNT_MAX : phase_ticks_reg + 1'b1;
    assign echo_inc  = (echo_ticks_reg == CNT_MAX) ? CNT_MAX : echo_ticks_reg + 1'b1;

    uer_div148 u_div (
        .ticks  (echo_inc),
        .inches (div_inches)
    );

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trig_width_reg <= TRIG_WIDTH_RESET;
            timeout_reg    <= TIMEOUT_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                REG_TRIGGER_WIDTH: trig_width_reg <= cfg_wdata[TRIG_W_BITS-1:0];
                REG_TIMEOUT:       timeout_reg    <= cfg_wdata[COUNT_BITS-1:0];
                default:           ;
            endcase
        end
    end

    // Phase sequencing and the result of one tick.
    always_comb
    begin
        phase_next       = phase_reg;
        phase_ticks_next = phase_ticks_reg;
        echo_ticks_next  = echo_ticks_reg;
        result           = '0;

        unique case (phase_reg)
            PH_WAIT, PH_MEASURE:
            begin
                if (phase_inc > timeout_reg)
                begin
                    // Timeout wins over an echo edge on the same tick.
                    result.timed_out = 1'b1;
                    phase_next       = PH_TRIGGER;
                    phase_ticks_next = '0;
                    echo_ticks_next  = '0;
                end
                else if (phase_reg == PH_WAIT)
                begin
                    phase_ticks_next = phase_inc;
                    if (echo)
                    begin
                        phase_next      = PH_MEASURE;
                        echo_ticks_next = '0;
                    end
                end
                else
                begin
                    phase_ticks_next = phase_inc;
                    echo_ticks_next  = echo_inc;
                    if (!echo)
                    begin
                        result.distance_valid  = 1'b1;
                        result.distance_inches = div_inches;
                        phase_next             = PH_TRIGGER;
                        phase_ticks_next       = '0;
                        echo_ticks_next        = '0;
                    end
                end
            end
            default:
            begin
                // Trigger phase; the unused code behaves the same way.
                phase_next = PH_TRIGGER;
                if (phase_ticks_reg > COUNT_BITS'(trig_width_reg))
                begin
                    phase_next       = PH_WAIT;
                    phase_ticks_next = '0;
                end
                else
                begin
                    result.trigger_level = 1'b1;
                    phase_ticks_next     = phase_inc;
                end
            end
        endcase

        result.phase = phase_next;
    end

    // State registers advance once per accepted tick.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_TRIGGER;
            phase_ticks_reg <= '0;
            echo_ticks_reg  <= '0;
        end
        else if (accept)
        begin
            phase_reg       <= phase_next;
            phase_ticks_reg <= phase_ticks_next;
            echo_ticks_reg  <= echo_ticks_next;
        end
    end

    // Result register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= result;
        end
    end

endmodule

`default_nettype wire
